[rtl/core/cflts_pkg.sv]
// ----------------------------------------------------------------------------
// cflts_pkg
// Shared types and constants for the local time step block: beat structs,
// shared unit commands and the sequencer states.
// ----------------------------------------------------------------------------
package cflts_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int CFL_W         = 24;
	localparam int ADDR_W        = 3;
	localparam int DATA_W        = 32;

	localparam logic REG_CFL_IDX = 1'b0;

	localparam logic [5:0] SQRT_LAST = 6'd31;
	localparam logic [5:0] DIV_LAST  = 6'd63;
	localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;

	typedef struct packed {
		logic [63:0] x_face_here;
		logic [63:0] x_face_before;
		logic [63:0] y_face_here;
		logic [63:0] y_face_before;
		logic [63:0] velocity;
		logic [31:0] beta_sq;
		logic [31:0] volume;
		logic        end_of_field;
	} item_t;

	typedef struct packed {
		logic [31:0] local_dt;
		logic [31:0] min_dt;
		logic        degenerate;
		logic        sweep_done;
	} result_t;

	typedef enum logic [1:0] {
		OP_MUL,
		OP_SQRT,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic        start;
		alu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] value;
	} alu_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AVG,
		ST_MX,
		ST_MY,
		ST_AMAG,
		ST_P1,
		ST_P2,
		ST_QUOT,
		ST_QL,
		ST_QH,
		ST_ROOT,
		ST_LO,
		ST_HI,
		ST_CV,
		ST_DT,
		ST_OUT
	} seq_state_t;

endpackage

[rtl/core/cflts_alu.sv]
// ----------------------------------------------------------------------------
// cflts_alu
// Shared arithmetic unit: registered 32x32 multiply, 64-bit square root
// at one result bit per cycle, 64/64 restoring divide at one bit per cycle.
// ----------------------------------------------------------------------------
module cflts_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  cflts_pkg::alu_req_t req,
	output cflts_pkg::alu_rsp_t rsp
);
	import cflts_pkg::*;

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic [5:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic [63:0] value_q;

	logic [63:0] prod;
	logic [64:0] trial;
	logic        div_ge;
	logic [63:0] root_b;
	logic        sqrt_ge;
	logic [63:0] rem_n;
	logic [63:0] quo_n;

	assign prod = req.a[31:0] * req.b[31:0];

	always_comb begin
		trial   = {rem_q, quo_q[63]};
		div_ge  = trial >= {1'b0, dvs_q};
		root_b  = quo_q + dvs_q;
		sqrt_ge = rem_q >= root_b;
		if (op_q == OP_DIV) begin
			rem_n = div_ge ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
			quo_n = {quo_q[62:0], div_ge};
		end else begin
			rem_n = sqrt_ge ? rem_q - root_b : rem_q;
			quo_n = sqrt_ge ? (quo_q >> 1) + dvs_q : quo_q >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				unique case (req.op)
					OP_MUL:  done_q <= 1'b1;
					OP_SQRT: begin
						busy_q <= 1'b1;
						cnt_q  <= SQRT_LAST;
					end
					OP_DIV:  begin
						busy_q <= 1'b1;
						cnt_q  <= DIV_LAST;
					end
					default: done_q <= 1'b1;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			unique case (req.op)
				OP_MUL:  value_q <= prod;
				OP_SQRT: begin
					rem_q <= req.a;
					quo_q <= '0;
					dvs_q <= SQRT_BIT0;
				end
				OP_DIV:  begin
					rem_q <= '0;
					quo_q <= req.a;
					dvs_q <= req.b;
				end
				default: value_q <= prod;
			endcase
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
			if (op_q == OP_SQRT) begin
				dvs_q <= dvs_q >> 2;
			end
			if (cnt_q == '0) begin
				value_q <= quo_n;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = value_q;

endmodule

[rtl/core/cfl_local_time_step.sv]
// ----------------------------------------------------------------------------
// cfl_local_time_step
// Local CFL time step per mesh cell for an artificial-compressibility solver.
// ----------------------------------------------------------------------------
// The block takes no new beat while a cell is in work. The work runs on the
// shared arithmetic unit: per face two 32-step square roots and one 64-step
// divide plus eight multiplies, then one multiply and a final 64-step divide
// for the step itself; a face whose magnitude is zero skips all of its work
// after the first square root. A finished result waits in the output register
// while the next cell is taken in. cfl_number is at byte address 0 of the
// APB port.
// ----------------------------------------------------------------------------
module cfl_local_time_step #(
	parameter int FRAC_BITS = cflts_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cflts_pkg::ADDR_W-1:0]    paddr,
	input  logic [cflts_pkg::DATA_W-1:0]    pwdata,
	output logic [cflts_pkg::DATA_W-1:0]    prdata,
	output logic                            pready,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cflts_pkg::item_t                item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cflts_pkg::result_t              result
);
	import cflts_pkg::*;

	localparam int SH = FRAC_BITS + 1;

	seq_state_t state_q, state_n;
	logic       issued_q;
	logic       face_q;
	logic       result_valid_q;
	logic [31:0] rmin_q;
	logic [CFL_W-1:0] cfl_q;

	item_t       in_q;
	result_t     result_q;
	logic [31:0] mx_q, my_q, umag_q, vmag_q, amag_q, dt_q;
	logic        sx_q, sy_q, su_q, sv_q, n1_q, n2_q, degen_q;
	logic [63:0] acc_q, m1_q, m2_q, q_q, bq_q, lo_q, sum_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic        accept;
	logic        out_free;
	logic        face_end;
	logic        op_state;
	logic [31:0] fh_x, fh_y, fb_x, fb_y;
	logic [32:0] sum_x, sum_y;
	logic [31:0] avg_x, avg_y, u_s, v_s;
	logic [63:0] num;
	logic [63:0] beta_sh;
	logic [63:0] eig;
	logic [31:0] mn;

	cflts_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// APB register
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_CFL_IDX) ? DATA_W'(cfl_q) : '0;

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	// face operand select and averages
	always_comb begin
		fh_x  = face_q ? in_q.y_face_here[31:0]    : in_q.x_face_here[31:0];
		fh_y  = face_q ? in_q.y_face_here[63:32]   : in_q.x_face_here[63:32];
		fb_x  = face_q ? in_q.y_face_before[31:0]  : in_q.x_face_before[31:0];
		fb_y  = face_q ? in_q.y_face_before[63:32] : in_q.x_face_before[63:32];
		sum_x = {fh_x[31], fh_x} + {fb_x[31], fb_x};
		sum_y = {fh_y[31], fh_y} + {fb_y[31], fb_y};
		avg_x = sum_x[32:1];
		avg_y = sum_y[32:1];
		u_s   = in_q.velocity[31:0];
		v_s   = in_q.velocity[63:32];
	end

	always_comb begin
		if (n1_q == n2_q) begin
			num = m1_q + m2_q;
		end else begin
			num = (m1_q > m2_q) ? m1_q - m2_q : m2_q - m1_q;
		end
		beta_sh = 64'(in_q.beta_sq) << (FRAC_BITS + 2);
		eig     = (alu_rsp.value << (32 - SH)) + (lo_q >> SH);
		mn      = (dt_q < rmin_q) ? dt_q : rmin_q;
	end

	assign face_end = alu_rsp.done &&
		((state_q == ST_AMAG && alu_rsp.value[31:0] == '0) || state_q == ST_HI);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_n = ST_AVG;
			ST_AVG:  state_n = ST_MX;
			ST_MX:   if (alu_rsp.done) state_n = ST_MY;
			ST_MY:   if (alu_rsp.done) state_n = ST_AMAG;
			ST_AMAG: begin
				if (alu_rsp.done) begin
					if (alu_rsp.value[31:0] != '0) state_n = ST_P1;
					else state_n = face_q ? ST_CV : ST_AVG;
				end
			end
			ST_P1:   if (alu_rsp.done) state_n = ST_P2;
			ST_P2:   if (alu_rsp.done) state_n = ST_QUOT;
			ST_QUOT: if (alu_rsp.done) state_n = ST_QL;
			ST_QL:   if (alu_rsp.done) state_n = ST_QH;
			ST_QH:   if (alu_rsp.done) state_n = ST_ROOT;
			ST_ROOT: if (alu_rsp.done) state_n = ST_LO;
			ST_LO:   if (alu_rsp.done) state_n = ST_HI;
			ST_HI:   if (alu_rsp.done) state_n = face_q ? ST_CV : ST_AVG;
			ST_CV:   if (alu_rsp.done) state_n = (sum_q == '0) ? ST_OUT : ST_DT;
			ST_DT:   if (alu_rsp.done) state_n = ST_OUT;
			ST_OUT:  if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// shared unit commands
	always_comb begin
		op_state   = 1'b1;
		alu_req.op = OP_MUL;
		alu_req.a  = '0;
		alu_req.b  = '0;
		unique case (state_q)
			ST_MX: begin
				alu_req.a = 64'(mx_q);
				alu_req.b = 64'(mx_q);
			end
			ST_MY: begin
				alu_req.a = 64'(my_q);
				alu_req.b = 64'(my_q);
			end
			ST_AMAG: begin
				alu_req.op = OP_SQRT;
				alu_req.a  = acc_q;
			end
			ST_P1: begin
				alu_req.a = 64'(umag_q);
				alu_req.b = 64'(mx_q);
			end
			ST_P2: begin
				alu_req.a = 64'(vmag_q);
				alu_req.b = 64'(my_q);
			end
			ST_QUOT: begin
				alu_req.op = OP_DIV;
				alu_req.a  = num;
				alu_req.b  = 64'(amag_q);
			end
			ST_QL: begin
				alu_req.a = 64'(q_q[31:0]);
				alu_req.b = 64'(q_q[31:0]);
			end
			ST_QH: begin
				alu_req.a = 64'(q_q[31:0]);
				alu_req.b = 64'(q_q[63:32]);
			end
			ST_ROOT: begin
				alu_req.op = OP_SQRT;
				alu_req.a  = acc_q;
			end
			ST_LO: begin
				alu_req.a = 64'(amag_q);
				alu_req.b = 64'(bq_q[31:0]);
			end
			ST_HI: begin
				alu_req.a = 64'(amag_q);
				alu_req.b = 64'(bq_q[63:32]);
			end
			ST_CV: begin
				alu_req.a = 64'(cfl_q);
				alu_req.b = 64'(in_q.volume);
			end
			ST_DT: begin
				alu_req.op = OP_DIV;
				alu_req.a  = acc_q;
				alu_req.b  = sum_q;
			end
			default: op_state = 1'b0;
		endcase
		alu_req.start = op_state && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			issued_q       <= 1'b0;
			face_q         <= 1'b0;
			result_valid_q <= 1'b0;
			rmin_q         <= '1;
			cfl_q          <= CFL_W'(1 << FRAC_BITS);
		end else begin
			state_q <= state_n;
			if (alu_rsp.done) begin
				issued_q <= 1'b0;
			end else if (alu_req.start) begin
				issued_q <= 1'b1;
			end
			if (accept) begin
				face_q <= 1'b0;
			end else if (face_end) begin
				face_q <= 1'b1;
			end
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
				rmin_q         <= in_q.end_of_field ? '1 : mn;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (psel && penable && pwrite && paddr[ADDR_W-1] == REG_CFL_IDX) begin
				cfl_q <= pwdata[CFL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q    <= item;
			sum_q   <= '0;
			degen_q <= 1'b0;
		end
		if (state_q == ST_AVG) begin
			sx_q   <= avg_x[31];
			sy_q   <= avg_y[31];
			mx_q   <= avg_x[31] ? ~avg_x + 32'd1 : avg_x;
			my_q   <= avg_y[31] ? ~avg_y + 32'd1 : avg_y;
			su_q   <= u_s[31];
			sv_q   <= v_s[31];
			umag_q <= u_s[31] ? ~u_s + 32'd1 : u_s;
			vmag_q <= v_s[31] ? ~v_s + 32'd1 : v_s;
		end
		if (alu_rsp.done) begin
			unique case (state_q)
				ST_MX:   acc_q <= alu_rsp.value;
				ST_MY:   acc_q <= acc_q + alu_rsp.value;
				ST_AMAG: begin
					amag_q <= alu_rsp.value[31:0];
					if (alu_rsp.value[31:0] == '0) degen_q <= 1'b1;
				end
				ST_P1: begin
					m1_q <= alu_rsp.value;
					n1_q <= (su_q ^ sx_q) && (alu_rsp.value != '0);
				end
				ST_P2: begin
					m2_q <= alu_rsp.value;
					n2_q <= (sv_q ^ sy_q) && (alu_rsp.value != '0);
				end
				ST_QUOT: q_q   <= alu_rsp.value;
				ST_QL:   acc_q <= alu_rsp.value;
				ST_QH:   acc_q <= acc_q + (alu_rsp.value << 33) + beta_sh;
				ST_ROOT: bq_q  <= q_q + 64'(alu_rsp.value[31:0]);
				ST_LO:   lo_q  <= alu_rsp.value;
				ST_HI:   sum_q <= sum_q + eig;
				ST_CV: begin
					acc_q <= alu_rsp.value;
					if (sum_q == '0) begin
						dt_q    <= '1;
						degen_q <= 1'b1;
					end
				end
				ST_DT:   dt_q <= (alu_rsp.value[63:32] != '0) ? '1 : alu_rsp.value[31:0];
				default: acc_q <= acc_q;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			result_q.local_dt   <= dt_q;
			result_q.min_dt     <= mn;
			result_q.degenerate <= degen_q;
			result_q.sweep_done <= in_q.end_of_field;
		end
	end

endmodule
